@@ rtl/cct_pkg.sv @@
// Package for the calendar clock: word types, operation codes and calendar constants.
// Shared by the channel interfaces and every module of the block; depends on nothing.
package cct_pkg;

    localparam int unsigned YEAR_W = 14;

    localparam logic [5:0]        SEC_TOP    = 6'd59;
    localparam logic [5:0]        MIN_TOP    = 6'd59;
    localparam logic [4:0]        HOUR_TOP   = 5'd23;
    localparam logic [3:0]        MONTH_TOP  = 4'd12;
    localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;

    localparam logic [5:0]        RST_SEC   = 6'd0;
    localparam logic [5:0]        RST_MIN   = 6'd0;
    localparam logic [4:0]        RST_HOUR  = 5'd0;
    localparam logic [4:0]        RST_DAY   = 5'd1;
    localparam logic [3:0]        RST_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0] RST_YEAR  = 14'd2000;

    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
    localparam logic [3:0] FEBRUARY     = 4'd2;

    // Reciprocal of 100 scaled by 2**19; exact quotient for every 14-bit year.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [YEAR_W-1:0] CENTURY = 14'd100;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [5:0]        set_second;
        logic [5:0]        set_minute;
        logic [4:0]        set_hour;
        logic [4:0]        set_day;
        logic [3:0]        set_month;
        logic [YEAR_W-1:0] set_year;
    } t_in_word;

    typedef struct packed {
        logic [5:0]        second_now;
        logic [5:0]        minute_now;
        logic [4:0]        hour_now;
        logic [4:0]        day_now;
        logic [3:0]        month_now;
        logic [YEAR_W-1:0] year_now;
        logic              date_advanced;
        logic              load_refused;
    } t_out_word;

    // Divisible by 4 and not by 100, or divisible by 400.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [26:0]       prod;
        logic [7:0]        quot;
        logic [YEAR_W-1:0] rem;
        prod = 27'(year) * 27'(RECIP_100);
        quot = prod[RECIP_SHIFT +: 8];
        rem  = year - YEAR_W'(YEAR_W'(quot) * CENTURY);
        return ((year[1:0] == 2'b00) && (rem != '0)) ||
               ((rem == '0) && (quot[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == '0 || month > MONTH_TOP) begin
            len = 5'd31;
        end else if (month == FEBRUARY && leap) begin
            len = FEB_LEAP_LEN;
        end else begin
            len = MONTH_LEN[month - 4'd1];
        end
        return len;
    endfunction

endpackage

@@ rtl/cct_if.sv @@
// Valid/ready channel interfaces for the calendar clock input and result words.
// Depends on cct_pkg for the word types.
interface cct_in_if;
    logic              valid;
    logic              ready;
    cct_pkg::t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cct_out_if;
    logic               valid;
    logic               ready;
    cct_pkg::t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ rtl/cct_in_stage.sv @@
// Input register of the calendar clock: captures one word and passes it on when taken.
// Depends on cct_pkg and cct_in_if.
module cct_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cct_in_if.sink            i_in,
    input  logic              i_take,
    output logic              o_valid,
    output cct_pkg::t_in_word o_data
);

    logic              r_valid;
    cct_pkg::t_in_word r_data;
    logic              n_valid;
    logic              w_accept;

    assign i_in.ready = !r_valid || i_take;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_in.data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/cct_calc.sv @@
// Time and date registers, tick and load logic, and the result register of the clock.
// Depends on cct_pkg and cct_out_if.
module cct_calc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cct_pkg::t_in_word i_data,
    output logic              o_take,
    cct_out_if.source         o_out
);

    logic [5:0]                 r_sec, n_sec;
    logic [5:0]                 r_min, n_min;
    logic [4:0]                 r_hour, n_hour;
    logic [4:0]                 r_day, n_day;
    logic [3:0]                 r_month, n_month;
    logic [cct_pkg::YEAR_W-1:0] r_year, n_year;
    logic                       r_out_valid;
    cct_pkg::t_out_word         r_out;
    cct_pkg::t_out_word         n_out;

    logic w_fire;
    logic w_load_ok;
    logic w_advanced;
    logic w_refused;
    logic w_sec_wrap, w_min_wrap, w_hour_wrap;
    logic [5:0] w_t_sec, w_t_min;
    logic [4:0] w_t_hour;

    assign o_take = !r_out_valid || o_out.ready;
    assign w_fire = i_valid && o_take;

    always_comb begin
        w_load_ok = (i_data.set_second <= cct_pkg::SEC_TOP) &&
                    (i_data.set_minute <= cct_pkg::MIN_TOP) &&
                    (i_data.set_hour <= cct_pkg::HOUR_TOP) &&
                    (i_data.set_month != '0) &&
                    (i_data.set_month <= cct_pkg::MONTH_TOP) &&
                    (i_data.set_year <= cct_pkg::YEAR_LIMIT) &&
                    (i_data.set_day != '0) &&
                    (i_data.set_day <= cct_pkg::days_in(i_data.set_month,
                                                        cct_pkg::is_leap(i_data.set_year)));
    end

    always_comb begin
        w_sec_wrap  = r_sec >= cct_pkg::SEC_TOP;
        w_min_wrap  = w_sec_wrap && (r_min >= cct_pkg::MIN_TOP);
        w_hour_wrap = w_min_wrap && (r_hour >= cct_pkg::HOUR_TOP);
        w_t_sec  = w_sec_wrap ? '0 : 6'(r_sec + 6'd1);
        w_t_min  = w_min_wrap ? '0 : (w_sec_wrap ? 6'(r_min + 6'd1) : r_min);
        w_t_hour = w_hour_wrap ? '0 : (w_min_wrap ? 5'(r_hour + 5'd1) : r_hour);
    end

    always_comb begin
        n_sec      = r_sec;
        n_min      = r_min;
        n_hour     = r_hour;
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        w_advanced = 1'b0;
        w_refused  = 1'b0;
        unique case (i_data.op)
            cct_pkg::OP_TICK: begin
                n_sec  = w_t_sec;
                n_min  = w_t_min;
                n_hour = w_t_hour;
                if (w_t_sec == '0 && w_t_min == '0 && w_t_hour == '0) begin
                    w_advanced = 1'b1;
                    if (r_day < cct_pkg::days_in(r_month, cct_pkg::is_leap(r_year))) begin
                        n_day = 5'(r_day + 5'd1);
                    end else if (r_month >= cct_pkg::MONTH_TOP) begin
                        n_day   = 5'd1;
                        n_month = 4'd1;
                        n_year  = (r_year >= cct_pkg::YEAR_LIMIT) ? '0 :
                                  cct_pkg::YEAR_W'(r_year + 1'b1);
                    end else begin
                        n_day   = 5'd1;
                        n_month = 4'(r_month + 4'd1);
                    end
                end
            end
            cct_pkg::OP_LOAD: begin
                if (w_load_ok) begin
                    n_sec   = i_data.set_second;
                    n_min   = i_data.set_minute;
                    n_hour  = i_data.set_hour;
                    n_day   = i_data.set_day;
                    n_month = i_data.set_month;
                    n_year  = i_data.set_year;
                end else begin
                    w_refused = 1'b1;
                end
            end
            default: begin
                w_refused = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out.second_now    = n_sec;
        n_out.minute_now    = n_min;
        n_out.hour_now      = n_hour;
        n_out.day_now       = n_day;
        n_out.month_now     = n_month;
        n_out.year_now      = n_year;
        n_out.date_advanced = w_advanced;
        n_out.load_refused  = w_refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= cct_pkg::RST_SEC;
            r_min       <= cct_pkg::RST_MIN;
            r_hour      <= cct_pkg::RST_HOUR;
            r_day       <= cct_pkg::RST_DAY;
            r_month     <= cct_pkg::RST_MONTH;
            r_year      <= cct_pkg::RST_YEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_sec   <= n_sec;
                r_min   <= n_min;
                r_hour  <= n_hour;
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sec <= cct_pkg::SEC_TOP) && (r_min <= cct_pkg::MIN_TOP) &&
        (r_hour <= cct_pkg::HOUR_TOP))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day != '0) && (r_month != '0) && (r_month <= cct_pkg::MONTH_TOP) &&
        (r_year <= cct_pkg::YEAR_LIMIT))
        else $error("date out of range");

    a_refused_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_data.op == cct_pkg::OP_LOAD && !w_load_ok) |=>
        ($stable(r_sec) && $stable(r_min) && $stable(r_hour) &&
         $stable(r_day) && $stable(r_month) && $stable(r_year) && r_out.load_refused))
        else $error("refused load changed the clock");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.date_advanced && r_out.load_refused))
        else $error("result word flags both date advance and refusal");

    a_advance_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.date_advanced) |->
        (r_out.second_now == '0 && r_out.minute_now == '0 && r_out.hour_now == '0))
        else $error("date advanced away from midnight");

endmodule

@@ rtl/calendar_clock_tick.sv @@
// Top level of the real-time clock and Gregorian calendar.
// Depends on cct_pkg, cct_if, cct_in_stage and cct_calc.
//
//   Channel   Dir   Word         Contents
//   i_in      in    t_in_word    tick or load with date and time
//   o_out     out   t_out_word   time, date and flags after the step
//
// One word is accepted per cycle while the result channel is not stalled; each word passes
// through the input register and then the time and date logic into the result register.
// Reset is synchronous and active low and sets the clock to 00:00:00, January 1, 2000.
// A stalled result holds in its register while the input register still takes one word.
module calendar_clock_tick (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cct_in_if.sink    i_in,
    cct_out_if.source o_out
);

    logic              w_valid;
    logic              w_take;
    cct_pkg::t_in_word w_data;

    cct_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_data  (w_data)
    );

    cct_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_data  (w_data),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for calendar_clock_tick: queued ticks and loads drive the input
// channel, and each result word is checked against a calendar predictor kept here.
// Depends on cct_pkg, cct_if and the calendar_clock_tick RTL.
module testbench;

    localparam int CLOCK_HALF  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 10;
    localparam int HOLD_AFTER  = 350;
    localparam int HOLD_CYCLES = 90;
    localparam int MAX_REPORTS = 10;
    localparam int MODEL_YEAR_LIMIT = 9999;

    typedef struct {
        cct_pkg::t_in_word word;
        bit                drain_first;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    cct_in_if  in_ch();
    cct_out_if out_ch();

    calendar_clock_tick dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_pending           pending_words[$];
    cct_pkg::t_out_word expected_words[$];

    int clock_sec   = 0;
    int clock_min   = 0;
    int clock_hour  = 0;
    int clock_day   = 1;
    int clock_month = 1;
    int clock_year  = 2000;

    int failures     = 0;
    int results_seen = 0;
    int cycles       = 0;
    int send_idle    = 0;
    int send_calm    = 0;
    int recv_stall   = 0;
    int recv_calm    = 0;
    int recv_hold    = 0;

    always #(CLOCK_HALF) i_clk = ~i_clk;

    function automatic bit leap_year(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int month_days(input int mon, input int yr);
        int lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mon < 1 || mon > 12) begin
            return 31;
        end
        if (mon == 2 && leap_year(yr)) begin
            return 29;
        end
        return lengths[mon - 1];
    endfunction

    function automatic cct_pkg::t_out_word advance_clock(input cct_pkg::t_in_word w);
        cct_pkg::t_out_word res;
        bit                 valid_load;
        res = '0;
        if (w.op == cct_pkg::OP_TICK) begin
            clock_sec++;
            if (clock_sec >= 60) begin
                clock_sec = 0;
                clock_min++;
                if (clock_min >= 60) begin
                    clock_min = 0;
                    clock_hour++;
                    if (clock_hour >= 24) begin
                        clock_hour = 0;
                    end
                end
            end
            if (clock_hour == 0 && clock_min == 0 && clock_sec == 0) begin
                res.date_advanced = 1'b1;
                if (clock_day < month_days(clock_month, clock_year)) begin
                    clock_day++;
                end else if (clock_month >= 12) begin
                    clock_day   = 1;
                    clock_month = 1;
                    clock_year  = (clock_year >= MODEL_YEAR_LIMIT) ? 0 : clock_year + 1;
                end else begin
                    clock_day = 1;
                    clock_month++;
                end
            end
        end else begin
            valid_load = w.set_second <= 59 && w.set_minute <= 59 && w.set_hour <= 23 &&
                         w.set_month >= 1 && w.set_month <= 12 &&
                         w.set_year <= MODEL_YEAR_LIMIT && w.set_day >= 1 &&
                         w.set_day <= month_days(w.set_month, w.set_year);
            if (valid_load) begin
                clock_sec   = w.set_second;
                clock_min   = w.set_minute;
                clock_hour  = w.set_hour;
                clock_day   = w.set_day;
                clock_month = w.set_month;
                clock_year  = w.set_year;
            end else begin
                res.load_refused = 1'b1;
            end
        end
        res.second_now = 6'(clock_sec);
        res.minute_now = 6'(clock_min);
        res.hour_now   = 5'(clock_hour);
        res.day_now    = 5'(clock_day);
        res.month_now  = 4'(clock_month);
        res.year_now   = 14'(clock_year);
        return res;
    endfunction

    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0) begin
            calm = $urandom_range(20, 60);
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_year();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 99) * 100;
            1: return $urandom_range(0, 24) * 400;
            2: return $urandom_range(9990, MODEL_YEAR_LIMIT);
            3: return $urandom_range(0, 2499) * 4;
            default: return $urandom_range(0, MODEL_YEAR_LIMIT);
        endcase
    endfunction

    task automatic queue_word(input cct_pkg::t_in_word w);
        t_pending p;
        p.word        = w;
        p.drain_first = (pending_words.size() == 260 || pending_words.size() == 560);
        pending_words.push_back(p);
    endtask

    task automatic queue_tick();
        cct_pkg::t_in_word w;
        w    = '0;
        w.op = cct_pkg::OP_TICK;
        queue_word(w);
    endtask

    task automatic queue_load(input int sec, input int mnt, input int hr, input int dy,
                              input int mon, input int yr);
        cct_pkg::t_in_word w;
        w.op         = cct_pkg::OP_LOAD;
        w.set_second = 6'(sec);
        w.set_minute = 6'(mnt);
        w.set_hour   = 5'(hr);
        w.set_day    = 5'(dy);
        w.set_month  = 4'(mon);
        w.set_year   = 14'(yr);
        queue_word(w);
    endtask

    task automatic build_stimulus();
        int                mon;
        int                yr;
        int                len;
        int                dy;
        int                ticks;
        int                kind;
        cct_pkg::t_in_word w;

        queue_tick();
        queue_load(59, 59, 23, 31, 12, 9999);
        queue_tick();
        queue_load(59, 59, 23, 28, 2, 2000);
        queue_tick();
        queue_load(59, 59, 23, 29, 2, 2000);
        queue_tick();
        queue_load(0, 0, 0, 29, 2, 1900);
        queue_load(59, 59, 23, 28, 2, 1900);
        queue_tick();
        queue_load(0, 0, 0, 29, 2, 2023);
        queue_load(59, 59, 23, 29, 2, 2024);
        queue_tick();
        queue_load(59, 59, 23, 30, 4, 2023);
        queue_tick();
        queue_load(59, 59, 12, 31, 1, 2023);
        queue_tick();
        queue_load(60, 0, 0, 1, 1, 2000);
        queue_load(0, 0, 24, 1, 1, 2000);
        queue_load(0, 0, 0, 0, 1, 2000);
        queue_load(0, 0, 0, 31, 4, 2000);
        queue_load(0, 0, 0, 1, 0, 2000);
        queue_load(0, 0, 0, 1, 13, 2000);
        queue_load(0, 0, 0, 1, 1, 10000);
        queue_load(63, 63, 31, 31, 15, 16383);
        queue_load(0, 0, 0, 1, 1, 0);
        queue_tick();

        while (pending_words.size() < RANDOM_ITEMS + 27) begin
            kind = $urandom_range(0, 99);
            mon  = $urandom_range(1, 12);
            yr   = pick_year();
            len  = month_days(mon, yr);
            dy   = $urandom_range(0, 1) ? len : $urandom_range(1, len);
            if (kind < 70) begin
                if ($urandom_range(0, 9) == 0) begin
                    mon = 12;
                    dy  = 31;
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_load($urandom_range(56, 59), 59, $urandom_range(0, 22), dy, mon, yr);
                end else begin
                    queue_load($urandom_range(45, 59), 59, 23, dy, mon, yr);
                end
                ticks = $urandom_range(1, 16);
            end else if (kind < 85) begin
                queue_load($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                           dy, mon, yr);
                ticks = $urandom_range(0, 5);
            end else begin
                if ($urandom_range(0, 1)) begin
                    w.op         = cct_pkg::OP_LOAD;
                    w.set_second = 6'($urandom);
                    w.set_minute = 6'($urandom);
                    w.set_hour   = 5'($urandom);
                    w.set_day    = 5'($urandom);
                    w.set_month  = 4'($urandom);
                    w.set_year   = 14'($urandom);
                    queue_word(w);
                end else begin
                    queue_load(59, 59, 23, len + 1, mon, yr);
                end
                ticks = $urandom_range(0, 3);
            end
            repeat (ticks) queue_tick();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            send_idle = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_words.push_back(advance_clock(in_ch.data));
                pending_words.delete(0);
                send_idle = pick_gap(send_calm);
            end
            if (in_ch.valid && !in_ch.ready) begin
            end else if (send_idle > 0) begin
                send_idle--;
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain_first && expected_words.size() != 0)) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_words[0].word;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cct_pkg::t_out_word want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_words.size() == 0) begin
                    if (failures < MAX_REPORTS) begin
                        $display("Unexpected result word at %0t: %p", $realtime, out_ch.data);
                    end
                    failures++;
                end else begin
                    want = expected_words.pop_front();
                    if (out_ch.data.second_now != want.second_now ||
                        out_ch.data.minute_now != want.minute_now ||
                        out_ch.data.hour_now != want.hour_now ||
                        out_ch.data.day_now != want.day_now ||
                        out_ch.data.month_now != want.month_now ||
                        out_ch.data.year_now != want.year_now ||
                        out_ch.data.date_advanced != want.date_advanced ||
                        out_ch.data.load_refused != want.load_refused) begin
                        if (failures < MAX_REPORTS) begin
                            $display("Mismatch at %0t: expected %p, actual %p",
                                     $realtime, want, out_ch.data);
                        end
                        failures++;
                    end
                end
                if (results_seen == HOLD_AFTER) begin
                    recv_hold = HOLD_CYCLES;
                end else begin
                    recv_stall = pick_gap(recv_calm);
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                out_ch.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() != 0 || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/cct_pkg.sv
rtl/cct_if.sv
rtl/cct_in_stage.sv
rtl/cct_calc.sv
rtl/calendar_clock_tick.sv
sim/testbench.sv
